@@ rtl/btu_pkg.sv @@
// shared types and constants for the branch target unit
package btu_pkg;

  // field widths fixed by the instruction format and stream payload
  localparam int unsigned KindWidth    = 2;
  localparam int unsigned OperandWidth = 26;
  localparam int unsigned WordWidth    = 64;
  localparam int unsigned CondWidth    = 4;
  localparam int unsigned RegIdxWidth  = 5;
  localparam int unsigned OutcomeWidth = 2;

  // slave tdata layout, lowest bit first
  localparam int unsigned InOperandLsb = 0;
  localparam int unsigned InPcLsb      = InOperandLsb + OperandWidth;
  localparam int unsigned InFlagNBit   = InPcLsb + WordWidth;
  localparam int unsigned InFlagZBit   = InFlagNBit + 1;
  localparam int unsigned InFlagVBit   = InFlagZBit + 1;
  localparam int unsigned InRegLsb     = InFlagVBit + 1;
  localparam int unsigned InUsedBits   = InRegLsb + WordWidth;
  localparam int unsigned InDataWidth  = ((InUsedBits + 7) / 8) * 8;

  localparam logic [RegIdxWidth-1:0] ZeroReg = 5'd31;

  typedef enum logic [KindWidth-1:0] {
    KindUncond  = 2'd0,
    KindCond    = 2'd1,
    KindInvalid = 2'd2,
    KindReg     = 2'd3
  } btu_kind_e;

  typedef enum logic [OutcomeWidth-1:0] {
    OutNotTaken = 2'd0,
    OutTaken    = 2'd1,
    OutFail     = 2'd2
  } btu_outcome_e;

  // condition codes understood by the conditional branch
  localparam logic [CondWidth-1:0] CondEq = 4'd0;
  localparam logic [CondWidth-1:0] CondNe = 4'd1;
  localparam logic [CondWidth-1:0] CondGe = 4'd10;
  localparam logic [CondWidth-1:0] CondLt = 4'd11;
  localparam logic [CondWidth-1:0] CondGt = 4'd12;
  localparam logic [CondWidth-1:0] CondLe = 4'd13;
  localparam logic [CondWidth-1:0] CondAl = 4'd14;

  typedef struct packed {
    logic n;
    logic z;
    logic v;
  } btu_flags_t;

endpackage

@@ rtl/branch_target_unit_core.sv @@
// branch target unit top level: input register, target logic, result register
//
//  channel   direction  tdata                                        tuser
//  s_axis    in         operand, current_pc, flag_n/z/v, reg value   branch_kind
//  m_axis    out        next_pc                                      outcome
//
// one beat in and one beat out per branch, passing the input register, then
// the result register; sustained rate one branch per cycle unless m_axis
// stalls; the two form a two-entry pipeline, stalls back up stage by stage
// s_axis_tready stays high while either stage has room or m_axis drains
// rst_ni clears both valid flags; payload registers are not reset
module branch_target_unit_core #(
  parameter int unsigned PC_WIDTH = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // operand[25:0], current_pc[89:26], flag_n[90], flag_z[91], flag_v[92],
  // register_value[156:93], zero padding above
  input  logic [btu_pkg::InDataWidth-1:0]     s_axis_tdata,
  // branch_kind[1:0]
  input  logic [btu_pkg::KindWidth-1:0]       s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // next_pc[63:0]
  output logic [btu_pkg::WordWidth-1:0]       m_axis_tdata,
  // outcome[1:0]
  output logic [btu_pkg::OutcomeWidth-1:0]    m_axis_tuser
);

  logic                             in_valid_q;
  btu_pkg::btu_kind_e               kind_q;
  logic [btu_pkg::OperandWidth-1:0] operand_q;
  logic [PC_WIDTH-1:0]              pc_q;
  btu_pkg::btu_flags_t              flags_q;
  logic [PC_WIDTH-1:0]              reg_value_q;

  logic                             out_valid_q;
  logic [PC_WIDTH-1:0]              next_pc_q;
  btu_pkg::btu_outcome_e            outcome_q;

  logic [PC_WIDTH-1:0]              next_pc_d;
  btu_pkg::btu_outcome_e            outcome_d;
  logic                             out_load;
  logic                             in_load;

  assign out_load      = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || !out_valid_q || m_axis_tready;
  assign in_load       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      kind_q      <= btu_pkg::btu_kind_e'(s_axis_tuser);
      operand_q   <= s_axis_tdata[btu_pkg::InOperandLsb +: btu_pkg::OperandWidth];
      pc_q        <= s_axis_tdata[btu_pkg::InPcLsb +: PC_WIDTH];
      flags_q.n   <= s_axis_tdata[btu_pkg::InFlagNBit];
      flags_q.z   <= s_axis_tdata[btu_pkg::InFlagZBit];
      flags_q.v   <= s_axis_tdata[btu_pkg::InFlagVBit];
      reg_value_q <= s_axis_tdata[btu_pkg::InRegLsb +: PC_WIDTH];
    end
  end

  btu_target #(
    .PC_WIDTH (PC_WIDTH)
  ) u_target (
    .kind_i      (kind_q),
    .operand_i   (operand_q),
    .pc_i        (pc_q),
    .flags_i     (flags_q),
    .reg_value_i (reg_value_q),
    .next_pc_o   (next_pc_d),
    .outcome_o   (outcome_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      next_pc_q <= next_pc_d;
      outcome_q <= outcome_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = btu_pkg::WordWidth'(next_pc_q);
  assign m_axis_tuser  = outcome_q;

`ifndef SYNTHESIS
  // a stalled input beat stays in its register
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !out_load |=> in_valid_q)
    else $error("input stage dropped a waiting beat");

  // a beat leaving the input stage always lands in the result register
  a_out_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q)
    else $error("result register missed a beat");

  // the reserved outcome code is never produced
  a_outcome_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == btu_pkg::OutNotTaken ||
                       m_axis_tuser == btu_pkg::OutTaken ||
                       m_axis_tuser == btu_pkg::OutFail))
    else $error("reserved outcome on m_axis");

  // bits above the pc width stay clear
  a_pc_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tdata >> PC_WIDTH) == '0))
    else $error("next pc exceeds pc width");
`endif

endmodule

@@ rtl/btu_target.sv @@
// next pc and outcome for one registered branch
module btu_target #(
  parameter int unsigned PC_WIDTH = 64
) (
  input  btu_pkg::btu_kind_e                  kind_i,
  input  logic [btu_pkg::OperandWidth-1:0]    operand_i,
  input  logic [PC_WIDTH-1:0]                 pc_i,
  input  btu_pkg::btu_flags_t                 flags_i,
  input  logic [PC_WIDTH-1:0]                 reg_value_i,
  output logic [PC_WIDTH-1:0]                 next_pc_o,
  output btu_pkg::btu_outcome_e               outcome_o
);

  logic [PC_WIDTH-1:0]             offset_uncond;
  logic [PC_WIDTH-1:0]             offset_cond;
  logic [PC_WIDTH-1:0]             offset_sel;
  logic [PC_WIDTH-1:0]             rel_target;
  logic [btu_pkg::CondWidth-1:0]   cond;
  logic [btu_pkg::RegIdxWidth-1:0] reg_idx;
  logic                            cond_valid;
  logic                            cond_take;
  logic                            n_eq_v;

  // word offsets, sign-extended and scaled by four
  assign offset_uncond = {{(PC_WIDTH - 28){operand_i[25]}}, operand_i[25:0], 2'b00};
  assign offset_cond   = {{(PC_WIDTH - 21){operand_i[23]}}, operand_i[23:5], 2'b00};
  assign offset_sel    = (kind_i == btu_pkg::KindUncond) ? offset_uncond : offset_cond;
  assign rel_target    = pc_i + offset_sel;

  assign cond    = operand_i[btu_pkg::CondWidth-1:0];
  assign reg_idx = operand_i[9:5];
  assign n_eq_v  = (flags_i.n == flags_i.v);

  always_comb begin
    cond_valid = 1'b1;
    cond_take  = 1'b0;
    unique case (cond)
      btu_pkg::CondEq: cond_take = flags_i.z;
      btu_pkg::CondNe: cond_take = !flags_i.z;
      btu_pkg::CondGe: cond_take = n_eq_v;
      btu_pkg::CondLt: cond_take = !n_eq_v;
      btu_pkg::CondGt: cond_take = !flags_i.z && n_eq_v;
      btu_pkg::CondLe: cond_take = flags_i.z || !n_eq_v;
      btu_pkg::CondAl: cond_take = 1'b1;
      default:         cond_valid = 1'b0;
    endcase
  end

  always_comb begin
    next_pc_o = pc_i;
    outcome_o = btu_pkg::OutNotTaken;
    unique case (kind_i)
      btu_pkg::KindUncond: begin
        next_pc_o = rel_target;
        outcome_o = btu_pkg::OutTaken;
      end
      btu_pkg::KindReg: begin
        // the zero register never redirects
        if (reg_idx != btu_pkg::ZeroReg) begin
          next_pc_o = reg_value_i;
          outcome_o = btu_pkg::OutTaken;
        end
      end
      btu_pkg::KindCond: begin
        if (!cond_valid) begin
          outcome_o = btu_pkg::OutFail;
        end else if (cond_take) begin
          next_pc_o = rel_target;
          outcome_o = btu_pkg::OutTaken;
        end
      end
      default: outcome_o = btu_pkg::OutFail;
    endcase
  end

endmodule

@@ tb/testbench.sv @@
// self-checking testbench for the branch target unit core
module testbench;

  localparam int unsigned TbPcWidth = 64;
  localparam int unsigned RandomItemsPerPhase = 335;
  localparam logic [btu_pkg::CondWidth-1:0] KnownConds [7] = '{
    btu_pkg::CondEq, btu_pkg::CondNe, btu_pkg::CondGe, btu_pkg::CondLt,
    btu_pkg::CondGt, btu_pkg::CondLe, btu_pkg::CondAl};

  typedef struct {
    logic [btu_pkg::WordWidth-1:0] next_pc;
    btu_pkg::btu_outcome_e         outcome;
  } pc_outcome_t;

  logic                                clk_i;
  logic                                rst_ni;
  logic                                s_axis_tvalid;
  logic                                s_axis_tready;
  logic [btu_pkg::InDataWidth-1:0]     s_axis_tdata;
  logic [btu_pkg::KindWidth-1:0]       s_axis_tuser;
  logic                                m_axis_tvalid;
  logic                                m_axis_tready;
  logic [btu_pkg::WordWidth-1:0]       m_axis_tdata;
  logic [btu_pkg::OutcomeWidth-1:0]    m_axis_tuser;

  pc_outcome_t pending_targets[$];
  int unsigned error_count;
  int unsigned idle_pct;
  int unsigned stall_pct;

  branch_target_unit_core #(
    .PC_WIDTH(TbPcWidth)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic pc_outcome_t predict_branch(
      btu_pkg::btu_kind_e kind,
      logic [btu_pkg::OperandWidth-1:0] operand,
      logic [btu_pkg::WordWidth-1:0] pc,
      btu_pkg::btu_flags_t flags,
      logic [btu_pkg::WordWidth-1:0] reg_value);
    pc_outcome_t res;
    logic [btu_pkg::WordWidth-1:0] pc_mask;
    logic taken;
    logic known;
    pc_mask = {btu_pkg::WordWidth{1'b1}} >> (btu_pkg::WordWidth - TbPcWidth);
    res.next_pc = pc;
    res.outcome = btu_pkg::OutNotTaken;
    taken = 1'b0;
    known = 1'b1;
    case (kind)
      btu_pkg::KindUncond: begin
        res.next_pc = pc + {{36{operand[25]}}, operand, 2'b00};
        res.outcome = btu_pkg::OutTaken;
      end
      btu_pkg::KindReg: begin
        if (operand[9:5] != btu_pkg::ZeroReg) begin
          res.next_pc = reg_value;
          res.outcome = btu_pkg::OutTaken;
        end
      end
      btu_pkg::KindCond: begin
        case (operand[btu_pkg::CondWidth-1:0])
          btu_pkg::CondEq: taken = flags.z;
          btu_pkg::CondNe: taken = !flags.z;
          btu_pkg::CondGe: taken = (flags.n == flags.v);
          btu_pkg::CondLt: taken = (flags.n != flags.v);
          btu_pkg::CondGt: taken = !flags.z && (flags.n == flags.v);
          btu_pkg::CondLe: taken = flags.z || (flags.n != flags.v);
          btu_pkg::CondAl: taken = 1'b1;
          default:         known = 1'b0;
        endcase
        if (!known) begin
          res.outcome = btu_pkg::OutFail;
        end else if (taken) begin
          res.next_pc = pc + {{43{operand[23]}}, operand[23:5], 2'b00};
          res.outcome = btu_pkg::OutTaken;
        end
      end
      default: res.outcome = btu_pkg::OutFail;
    endcase
    res.next_pc &= pc_mask;
    return res;
  endfunction

  task automatic report_mismatch(string what);
    error_count++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // one beat on s_axis, with a random idle gap before it
  task automatic send_branch(btu_pkg::btu_kind_e kind,
                             logic [btu_pkg::OperandWidth-1:0] operand,
                             logic [btu_pkg::WordWidth-1:0] pc,
                             btu_pkg::btu_flags_t flags,
                             logic [btu_pkg::WordWidth-1:0] reg_value);
    logic [btu_pkg::InDataWidth-1:0] beat;
    beat = '0;
    beat[btu_pkg::InOperandLsb +: btu_pkg::OperandWidth] = operand;
    beat[btu_pkg::InPcLsb +: btu_pkg::WordWidth]         = pc;
    beat[btu_pkg::InFlagNBit]                            = flags.n;
    beat[btu_pkg::InFlagZBit]                            = flags.z;
    beat[btu_pkg::InFlagVBit]                            = flags.v;
    beat[btu_pkg::InRegLsb +: btu_pkg::WordWidth]        = reg_value;
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= {$urandom, $urandom, $urandom, $urandom, $urandom};
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= beat;
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_targets.push_back(predict_branch(kind, operand, pc, flags, reg_value));
  endtask

  // receiver side: random back-pressure and result checking
  always @(posedge clk_i or negedge rst_ni) begin
    pc_outcome_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_targets.size() == 0) begin
          report_mismatch($sformatf("unexpected beat next_pc=%h outcome=%0d",
                                    m_axis_tdata, m_axis_tuser));
        end else begin
          want = pending_targets.pop_front();
          if (m_axis_tdata !== want.next_pc)
            report_mismatch($sformatf("next_pc %h, expected %h", m_axis_tdata, want.next_pc));
          if (m_axis_tuser !== want.outcome)
            report_mismatch($sformatf("outcome %0d, expected %s", m_axis_tuser,
                                      want.outcome.name()));
        end
      end
    end
  end

  function automatic logic [btu_pkg::WordWidth-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic btu_pkg::btu_flags_t rand_flags();
    return btu_pkg::btu_flags_t'(3'($urandom));
  endfunction

  task automatic test_unconditional_extremes();
    send_branch(btu_pkg::KindUncond, 26'h0000000, rand_word(), 3'b000, rand_word());
    send_branch(btu_pkg::KindUncond, 26'h1FFFFFF, {btu_pkg::WordWidth{1'b1}}, 3'b111,
                rand_word());
    send_branch(btu_pkg::KindUncond, 26'h2000000, 64'h0, 3'b101, rand_word());
    send_branch(btu_pkg::KindUncond, 26'h3FFFFFF, 64'h0, 3'b010,
                {btu_pkg::WordWidth{1'b1}});
  endtask

  // every known condition code, once with z set and once with random flags,
  // offsets at both ends of the 19-bit range, unused bits randomised
  task automatic test_conditions();
    logic [btu_pkg::OperandWidth-1:0] operand;
    for (int i = 0; i < 7; i++) begin
      operand = btu_pkg::OperandWidth'($urandom);
      operand[btu_pkg::CondWidth-1:0] = KnownConds[i];
      operand[23:5] = (i % 2 == 0) ? 19'h3FFFF : 19'h40000;
      send_branch(btu_pkg::KindCond, operand, rand_word(), 3'b010, rand_word());
      operand[23:5] = ~operand[23:5];
      send_branch(btu_pkg::KindCond, operand, rand_word(), rand_flags(), rand_word());
    end
  endtask

  task automatic test_register_branches();
    send_branch(btu_pkg::KindReg, {16'hFFFF, btu_pkg::ZeroReg, 5'h1F}, rand_word(), 3'b111,
                rand_word());
    send_branch(btu_pkg::KindReg, 26'h0, rand_word(), 3'b000, {btu_pkg::WordWidth{1'b1}});
    send_branch(btu_pkg::KindReg, {16'hFFFF, 5'd30, 5'h1F}, rand_word(), 3'b000, 64'h0);
  endtask

  task automatic test_decode_failures();
    send_branch(btu_pkg::KindInvalid, btu_pkg::OperandWidth'($urandom), rand_word(), 3'b111,
                rand_word());
    send_branch(btu_pkg::KindCond, {22'($urandom), 4'hF}, rand_word(), 3'b000, rand_word());
    send_branch(btu_pkg::KindCond, {22'($urandom), 4'h2}, rand_word(), 3'b010, rand_word());
    send_branch(btu_pkg::KindCond, {22'($urandom), 4'h9}, rand_word(), 3'b101, rand_word());
  endtask

  task automatic test_random_traffic(int unsigned idle, int unsigned stall);
    btu_pkg::btu_kind_e kind;
    logic [btu_pkg::OperandWidth-1:0] operand;
    logic [btu_pkg::WordWidth-1:0] pc;
    int unsigned pick;
    idle_pct  = idle;
    stall_pct = stall;
    for (int i = 0; i < RandomItemsPerPhase; i++) begin
      pick = $urandom_range(99);
      kind = (pick < 25) ? btu_pkg::KindUncond : (pick < 70) ? btu_pkg::KindCond :
             (pick < 95) ? btu_pkg::KindReg : btu_pkg::KindInvalid;
      operand = btu_pkg::OperandWidth'($urandom);
      if (kind == btu_pkg::KindCond && $urandom_range(99) < 80)
        operand[btu_pkg::CondWidth-1:0] = KnownConds[$urandom_range(6)];
      if (kind == btu_pkg::KindReg && $urandom_range(99) < 15)
        operand[9:5] = btu_pkg::ZeroReg;
      // bias a few program counters to the ends so target arithmetic wraps
      pick = $urandom_range(19);
      pc = (pick == 0) ? '0 : (pick == 1) ? '1 : rand_word();
      send_branch(kind, operand, pc, rand_flags(), rand_word());
    end
  endtask

  initial begin
    error_count = 0;
    idle_pct = 0;
    stall_pct = 0;
    rst_ni <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= btu_pkg::KindUncond;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    stall_pct = 30;
    idle_pct = 30;
    test_unconditional_extremes();
    test_conditions();
    test_register_branches();
    test_decode_failures();

    test_random_traffic(0, 0);
    test_random_traffic(88, 0);
    test_random_traffic(0, 88);
    test_random_traffic(30, 30);

    s_axis_tvalid <= 1'b0;
    stall_pct = 0;
    while (pending_targets.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("branch_target_unit_core regression: pass");
    end else begin
      $display("branch_target_unit_core regression: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("branch_target_unit_core regression: fail");
    $finish;
  end

endmodule
